>>> hw/rtl/ams_pkg.sv
// Shared definitions for the axial mean subtract block: field widths,
// register indexes, opcodes, reset values and the configuration struct.
// No dependencies.
`timescale 1ns / 1ps

package ams_pkg;

  // Widths of the item fields and configuration registers.
  localparam int COORD_W    = 6;
  localparam int NCOORD_W   = COORD_W + 1;  // neighbours stay below a 7-bit size
  localparam int STEP_W     = 6;
  localparam int REACH_W    = 4;
  localparam int SIZE_W     = 7;
  localparam int SAMPLE_W   = 8;
  localparam int FILT_W     = 8;
  localparam int NCNT_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // Default store geometry.
  localparam int DEF_MAX_X     = 64;
  localparam int DEF_MAX_Y     = 64;
  localparam int DEF_MAX_Z     = 64;
  localparam int DEF_MAX_REACH = 8;

  // Opcodes of an input word.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd4;

  // Reset values of the registers.
  localparam logic [STEP_W-1:0]  RST_STEP  = 6'd5;
  localparam logic [REACH_W-1:0] RST_REACH = 4'd3;
  localparam logic [SIZE_W-1:0]  RST_SIZE  = 7'd64;

  typedef struct packed {
    logic [STEP_W-1:0]  step;
    logic [REACH_W-1:0] reach;
    logic [SIZE_W-1:0]  size_x;
    logic [SIZE_W-1:0]  size_y;
    logic [SIZE_W-1:0]  size_z;
  } cfg_t;

  // Address bits needed for one axis of the store.
  function automatic int axis_bits(int extent);
    return (extent > 1) ? $clog2(extent) : 1;
  endfunction

endpackage

>>> hw/rtl/ams_if.sv
// Channel interfaces of the axial mean subtract block: input words,
// result words and configuration writes. Depends on ams_pkg.
`timescale 1ns / 1ps

interface ams_req_if import ams_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [COORD_W-1:0]  pos_x;
  logic [COORD_W-1:0]  pos_y;
  logic [COORD_W-1:0]  pos_z;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, opcode, pos_x, pos_y, pos_z, sample, input ready);
  modport sink   (input valid, opcode, pos_x, pos_y, pos_z, sample, output ready);
endinterface

interface ams_rsp_if import ams_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FILT_W-1:0] filtered;
  logic [NCNT_W-1:0] neighbour_count;

  modport source (output valid, filtered, neighbour_count, input ready);
  modport sink   (input valid, filtered, neighbour_count, output ready);
endinterface

interface ams_cfg_if import ams_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/ams_voxel_mem.sv
// Voxel store: simple dual-port synchronous memory, one write port and one
// read port with registered read data. Depends on ams_pkg.
`timescale 1ns / 1ps

module ams_voxel_mem import ams_pkg::*; #(
  parameter int AW = 18
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [SAMPLE_W-1:0] wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output logic [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [0:(1 << AW) - 1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/ams_div.sv
// Restoring divider that retires one quotient bit per cycle.
// Depends on ams_pkg only for the house import.
`timescale 1ns / 1ps

module ams_div import ams_pkg::*; #(
  parameter int NUM_W = 14,
  parameter int DEN_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int SC_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [SC_W-1:0]  steps;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  always_comb begin
    shifted = {rem, quo[NUM_W-1]};
    diff    = shifted - {1'b0, dvs};
    fits    = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= SC_W'(NUM_W);
        rem   <= '0;
        quo   <= dividend;
        dvs   <= divisor;
      end else if (busy) begin
        // The partial remainder always stays below the divisor.
        rem   <= fits ? DEN_W'(diff) : DEN_W'(shifted);
        quo   <= {quo[NUM_W-2:0], fits};
        steps <= steps - SC_W'(1);
        if (steps == SC_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

>>> hw/rtl/ams_ctrl.sv
// Sequencer of the axial mean subtract block: writes loads into the voxel
// store, walks the neighbours of a query through the read port, sums them,
// then runs the mean subtraction through the serial divider. Depends on ams_pkg.
`timescale 1ns / 1ps

module ams_ctrl import ams_pkg::*; #(
  parameter int MAX_X     = DEF_MAX_X,
  parameter int MAX_Y     = DEF_MAX_Y,
  parameter int MAX_Z     = DEF_MAX_Z,
  parameter int MAX_REACH = DEF_MAX_REACH,
  parameter int AW        = 18,
  parameter int CNT_W     = 6,
  parameter int NUM_W     = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                opcode,
  input  logic [COORD_W-1:0]  pos_x,
  input  logic [COORD_W-1:0]  pos_y,
  input  logic [COORD_W-1:0]  pos_z,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FILT_W-1:0]   filtered,
  output logic [NCNT_W-1:0]   neighbour_count,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [SAMPLE_W-1:0] mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  input  logic [SAMPLE_W-1:0] mem_rdata,
  output logic                div_start,
  output logic [NUM_W-1:0]    div_dividend,
  output logic [CNT_W-1:0]    div_divisor,
  input  logic                div_done,
  input  logic [NUM_W-1:0]    div_quo
);

  localparam int XW     = axis_bits(MAX_X);
  localparam int YW     = axis_bits(MAX_Y);
  localparam int ZW     = axis_bits(MAX_Z);
  localparam int RNG_W  = $clog2(MAX_REACH + 1);
  localparam int DIST_W = STEP_W + RNG_W;
  localparam int POS_W  = DIST_W + 1;
  localparam int SUM_W  = SAMPLE_W + CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_CENTER, S_CWAIT, S_MUL, S_DIV, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    D_XM, D_XP, D_YM, D_YP, D_ZM, D_ZP
  } dir_t;

  state_t              state;
  dir_t                dir;
  logic [COORD_W-1:0]  qx, qy, qz;
  logic [SIZE_W-1:0]   sx, sy, sz;
  logic [RNG_W-1:0]    rings;
  logic [RNG_W-1:0]    ring;
  logic [STEP_W-1:0]   stp;
  logic [DIST_W-1:0]   ring_dist;
  logic                rd_pend;
  logic [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]    cnt;
  logic [SAMPLE_W-1:0] c;
  logic [NUM_W-1:0]    num;
  logic [FILT_W-1:0]   res;

  logic [SIZE_W-1:0]   qsx, qsy, qsz;
  logic [RNG_W-1:0]    qrings;
  logic                outside;
  logic                load_inb;
  logic                accept;

  logic [COORD_W-1:0]  axc;
  logic [SIZE_W-1:0]   axs;
  logic                minus;
  logic [POS_W-1:0]    up_pos;
  logic [POS_W-1:0]    dn_pos;
  logic                cand_ok;
  logic [NCOORD_W-1:0] cand_pos;
  logic [NCOORD_W-1:0] nx, ny, nz;

  function automatic logic [AW-1:0] vaddr(logic [NCOORD_W-1:0] x,
                                          logic [NCOORD_W-1:0] y,
                                          logic [NCOORD_W-1:0] z);
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] tz;
    tx = 32'(x);
    ty = 32'(y);
    tz = 32'(z);
    return {tz[ZW-1:0], ty[YW-1:0], tx[XW-1:0]};
  endfunction

  // Effective sizes and ring count for an arriving query.
  always_comb begin
    qsx     = (32'(cfg.size_x) > MAX_X) ? SIZE_W'(MAX_X) : cfg.size_x;
    qsy     = (32'(cfg.size_y) > MAX_Y) ? SIZE_W'(MAX_Y) : cfg.size_y;
    qsz     = (32'(cfg.size_z) > MAX_Z) ? SIZE_W'(MAX_Z) : cfg.size_z;
    qrings  = (32'(cfg.reach) > MAX_REACH) ? RNG_W'(MAX_REACH) : RNG_W'(cfg.reach);
    outside = (SIZE_W'(pos_x) >= qsx) || (SIZE_W'(pos_y) >= qsy) ||
              (SIZE_W'(pos_z) >= qsz);
    load_inb = (32'(pos_x) < MAX_X) && (32'(pos_y) < MAX_Y) && (32'(pos_z) < MAX_Z);
  end

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign mem_we    = accept && (opcode == OP_LOAD) && load_inb;
  assign mem_waddr = vaddr(NCOORD_W'(pos_x), NCOORD_W'(pos_y), NCOORD_W'(pos_z));
  assign mem_wdata = sample;

  // One candidate neighbour per cycle: pick the axis, then test the ring
  // distance against the lower edge or the upper size.
  always_comb begin
    unique case (dir)
      D_XM, D_XP: begin
        axc = qx;
        axs = sx;
      end
      D_YM, D_YP: begin
        axc = qy;
        axs = sy;
      end
      D_ZM, D_ZP: begin
        axc = qz;
        axs = sz;
      end
      default: begin
        axc = qx;
        axs = sx;
      end
    endcase
    minus    = (dir == D_XM) || (dir == D_YM) || (dir == D_ZM);
    up_pos   = POS_W'(axc) + POS_W'(ring_dist);
    dn_pos   = POS_W'(axc) - POS_W'(ring_dist);
    cand_ok  = minus ? (POS_W'(axc) >= POS_W'(ring_dist)) : (up_pos < POS_W'(axs));
    cand_pos = minus ? NCOORD_W'(dn_pos) : NCOORD_W'(up_pos);
    nx = ((dir == D_XM) || (dir == D_XP)) ? cand_pos : NCOORD_W'(qx);
    ny = ((dir == D_YM) || (dir == D_YP)) ? cand_pos : NCOORD_W'(qy);
    nz = ((dir == D_ZM) || (dir == D_ZP)) ? cand_pos : NCOORD_W'(qz);
  end

  assign mem_re    = ((state == S_SCAN) && cand_ok) || (state == S_CENTER);
  assign mem_raddr = (state == S_SCAN) ? vaddr(nx, ny, nz) :
                     vaddr(NCOORD_W'(qx), NCOORD_W'(qy), NCOORD_W'(qz));

  assign div_start    = (state == S_MUL) && (num > NUM_W'(sum));
  assign div_dividend = num - NUM_W'(sum);
  assign div_divisor  = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
      rings     <= '0;
    end else begin
      rd_pend <= (state == S_SCAN) && cand_ok;
      if (rd_pend) begin
        sum <= sum + SUM_W'(mem_rdata);
        cnt <= cnt + CNT_W'(1);
      end
      // In the done state the output register is refilled instead.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && (opcode == OP_QUERY)) begin
            qx        <= pos_x;
            qy        <= pos_y;
            qz        <= pos_z;
            sx        <= qsx;
            sy        <= qsy;
            sz        <= qsz;
            rings     <= qrings;
            stp       <= cfg.step;
            ring      <= RNG_W'(1);
            ring_dist <= DIST_W'(cfg.step);
            dir       <= D_XM;
            sum       <= '0;
            cnt       <= '0;
            res       <= '0;
            if (outside) begin
              state <= S_DONE;
            end else if (qrings == '0) begin
              state <= S_CENTER;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          unique case (dir)
            D_XM: dir <= D_XP;
            D_XP: dir <= D_YM;
            D_YM: dir <= D_YP;
            D_YP: dir <= D_ZM;
            D_ZM: dir <= D_ZP;
            default: begin
              dir <= D_XM;
              if (ring == rings) begin
                state <= S_CENTER;
              end else begin
                ring      <= ring + RNG_W'(1);
                ring_dist <= ring_dist + DIST_W'(stp);
              end
            end
          endcase
        end
        S_CENTER: begin
          state <= S_CWAIT;
        end
        S_CWAIT: begin
          c <= mem_rdata;
          if (cnt == '0) begin
            res   <= mem_rdata;
            state <= S_DONE;
          end else begin
            num   <= NUM_W'(mem_rdata) * NUM_W'(cnt);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (num > NUM_W'(sum)) begin
            state <= S_DIV;
          end else begin
            res   <= '0;
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res   <= FILT_W'(div_quo);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            filtered        <= res;
            neighbour_count <= NCNT_W'(cnt);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= 6 * 32'(rings))
    else $error("neighbour count exceeds six per ring");

  a_quo_le_center: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (div_quo <= NUM_W'(c)))
    else $error("quotient larger than the centre value");

  a_no_late_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_CWAIT) |-> !rd_pend)
    else $error("neighbour read still pending at centre capture");

  a_no_rings_no_cnt: assert property (@(posedge clk) disable iff (rst)
    ((state == S_CWAIT) && (rings == '0)) |-> (cnt == '0))
    else $error("neighbours counted with zero rings");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result word raised outside the done state");

endmodule

>>> hw/rtl/axial_mean_subtract_3d.sv
// Top level of the axial mean subtract block: configuration registers and
// the store, sequencer and divider. Depends on ams_pkg, ams_if,
// ams_voxel_mem, ams_div and ams_ctrl.
`timescale 1ns / 1ps

// Usage. The block holds an 8-bit volume in an internal memory. Input words
// arrive on req: a load word (opcode 0) writes one voxel, a query word
// (opcode 1) yields one result word on rsp, holding the voxel minus the mean
// of its axial neighbours at multiples of step, truncated and clamped at
// zero, and the number of neighbours used. Configuration writes on cfg are
// always taken, at one register per word, and must only be issued while the
// block is idle.
// Flow. A load is written at the edge that accepts it, and req is ready again in
// the next cycle. A query reads its candidate neighbours (six per ring) one per
// cycle through the memory read port, reads the centre voxel (S_CENTER, S_CWAIT),
// multiplies, runs a restoring divide at one bit per cycle over the 14-bit
// numerator (for the default reach limit) and fills the output register. A query
// outside the volume skips all of this; one with no neighbours or a centre not
// above the mean skips the divide. The single memory read port and the serial
// divider set the query time; queries are handled one at a time.
// Reset restores the register defaults and idles the channels. Voxel contents
// are not cleared; a voxel must be loaded before it is read. When the receiver
// stalls, the finished word waits in the output register; the block still
// takes further words, and a following query holds in its last step until the
// register is free.
module axial_mean_subtract_3d import ams_pkg::*; #(
  parameter int MAX_X     = DEF_MAX_X,
  parameter int MAX_Y     = DEF_MAX_Y,
  parameter int MAX_Z     = DEF_MAX_Z,
  parameter int MAX_REACH = DEF_MAX_REACH
) (
  input logic     clk,
  input logic     rst,
  ams_req_if.sink   req,
  ams_rsp_if.source rsp,
  ams_cfg_if.sink   cfg
);

  // Store address is the concatenation of the three axis fields.
  localparam int AW    = axis_bits(MAX_X) + axis_bits(MAX_Y) + axis_bits(MAX_Z);
  // Neighbour count reaches six per ring.
  localparam int CNT_W = $clog2(6 * MAX_REACH + 1);
  // Numerator of the mean subtraction is centre times count.
  localparam int NUM_W = SAMPLE_W + CNT_W;

  cfg_t cfg_q;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [SAMPLE_W-1:0] mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [SAMPLE_W-1:0] mem_rdata;
  logic                div_start;
  logic [NUM_W-1:0]    div_dividend;
  logic [CNT_W-1:0]    div_divisor;
  logic                div_done;
  logic [NUM_W-1:0]    div_quo;

  // Configuration registers. Writes to indexes past the last register are
  // accepted and dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.step   <= RST_STEP;
      cfg_q.reach  <= RST_REACH;
      cfg_q.size_x <= RST_SIZE;
      cfg_q.size_y <= RST_SIZE;
      cfg_q.size_z <= RST_SIZE;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_STEP:   cfg_q.step   <= cfg.data[STEP_W-1:0];
        CFG_REACH:  cfg_q.reach  <= cfg.data[REACH_W-1:0];
        CFG_SIZE_X: cfg_q.size_x <= cfg.data[SIZE_W-1:0];
        CFG_SIZE_Y: cfg_q.size_y <= cfg.data[SIZE_W-1:0];
        CFG_SIZE_Z: cfg_q.size_z <= cfg.data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ams_voxel_mem #(
    .AW(AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ams_div #(
    .NUM_W(NUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  ams_ctrl #(
    .MAX_X     (MAX_X),
    .MAX_Y     (MAX_Y),
    .MAX_Z     (MAX_Z),
    .MAX_REACH (MAX_REACH),
    .AW        (AW),
    .CNT_W     (CNT_W),
    .NUM_W     (NUM_W)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg_q),
    .in_valid        (req.valid),
    .in_ready        (req.ready),
    .opcode          (req.opcode),
    .pos_x           (req.pos_x),
    .pos_y           (req.pos_y),
    .pos_z           (req.pos_z),
    .sample          (req.sample),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .filtered        (rsp.filtered),
    .neighbour_count (rsp.neighbour_count),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata),
    .div_start       (div_start),
    .div_dividend    (div_dividend),
    .div_divisor     (div_divisor),
    .div_done        (div_done),
    .div_quo         (div_quo)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for axial_mean_subtract_3d. It drives load and query words,
// writes the five registers, predicts each result and compares it with the block.
// Depends on ams_pkg, the channel interfaces in ams_if and the block's RTL.

module tb;
  import ams_pkg::*;

  localparam int MAX_X         = DEF_MAX_X;
  localparam int MAX_Y         = DEF_MAX_Y;
  localparam int MAX_Z         = DEF_MAX_Z;
  localparam int MAX_REACH     = DEF_MAX_REACH;
  localparam int VOXELS        = MAX_X * MAX_Y * MAX_Z;
  localparam int ITEM_TARGET   = 1850;
  // Cycles left after the last result before a register write or the end of
  // the run: well above the longest query.
  localparam int SETTLE_CYCLES = 6 * MAX_REACH + 60;
  // Long receiver hold-off that backs the block up into its input.
  localparam int HOLD_CYCLES   = 500;
  localparam longint TIMEOUT_NS = 20_000_000;

  typedef struct packed {
    logic                opcode;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  z;
    logic [SAMPLE_W-1:0] sample;
  } voxel_word_t;

  typedef struct packed {
    logic [FILT_W-1:0] filtered;
    logic [NCNT_W-1:0] neighbour_count;
  } mean_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ams_req_if req_ch ();
  ams_rsp_if rsp_ch ();
  ams_cfg_if cfg_ch ();

  axial_mean_subtract_3d u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Geometry helpers shared by the predictor and the stimulus generator.
  // ---------------------------------------------------------------------------

  function automatic int clip(input int v, input int m);
    return (v > m) ? m : v;
  endfunction

  // Store layout: x runs fastest, then y, then z.
  function automatic int voxel_addr(input int x, input int y, input int z);
    return (z * MAX_Y + y) * MAX_X + x;
  endfunction

  // Lists the addresses of every axial neighbour that a query at (x,y,z) would
  // average under the settings c. Returns 0 when the query lies outside the
  // volume in use, in which case nothing is read at all. Sizes above the store
  // and a reach above its limit are saturated, as the block does.
  function automatic bit gather_taps(input cfg_t c, input int x, input int y, input int z,
                                     ref int taps[$]);
    int sx, sy, sz, rings, n, d;
    taps.delete();
    sx = clip(c.size_x, MAX_X);
    sy = clip(c.size_y, MAX_Y);
    sz = clip(c.size_z, MAX_Z);
    if (x >= sx || y >= sy || z >= sz) begin
      return 1'b0;
    end
    rings = clip(c.reach, MAX_REACH);
    for (n = 1; n <= rings; n++) begin
      d = c.step * n;
      // Lower side counts when the coordinate reaches the distance, upper side
      // when the neighbour still lies below the size in use.
      if (x >= d)     taps.push_back(voxel_addr(x - d, y, z));
      if (x + d < sx) taps.push_back(voxel_addr(x + d, y, z));
      if (y >= d)     taps.push_back(voxel_addr(x, y - d, z));
      if (y + d < sy) taps.push_back(voxel_addr(x, y + d, z));
      if (z >= d)     taps.push_back(voxel_addr(x, y, z - d));
      if (z + d < sz) taps.push_back(voxel_addr(x, y, z + d));
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: a shadow copy of the volume and the registers, and the queue of
  // results that accepted queries are owed.
  // ---------------------------------------------------------------------------

  class axial_mean_tracker;
    bit [SAMPLE_W-1:0] volume [VOXELS];
    cfg_t              regs;
    mean_result_t      owed_means[$];
    int unsigned       errors;
    int unsigned       compared;

    function new();
      regs.step   = RST_STEP;
      regs.reach  = RST_REACH;
      regs.size_x = RST_SIZE;
      regs.size_y = RST_SIZE;
      regs.size_z = RST_SIZE;
      errors      = 0;
      compared    = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_STEP:   regs.step   = data[STEP_W-1:0];
        CFG_REACH:  regs.reach  = data[REACH_W-1:0];
        CFG_SIZE_X: regs.size_x = data[SIZE_W-1:0];
        CFG_SIZE_Y: regs.size_y = data[SIZE_W-1:0];
        CFG_SIZE_Z: regs.size_z = data[SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    // A load updates the shadow volume; a query computes the centre minus the
    // neighbour mean, truncated and clamped at zero, and queues it.
    function void take_word(input voxel_word_t w);
      int           taps[$];
      int           sum, cnt, centre, num, res;
      mean_result_t r;
      if (w.opcode == OP_LOAD) begin
        volume[voxel_addr(w.x, w.y, w.z)] = w.sample;
        return;
      end
      r = '0;
      if (gather_taps(regs, w.x, w.y, w.z, taps)) begin
        sum = 0;
        foreach (taps[i]) sum += volume[taps[i]];
        cnt    = taps.size();
        centre = volume[voxel_addr(w.x, w.y, w.z)];
        if (cnt == 0) begin
          res = centre;
        end else begin
          num = centre * cnt;
          res = (num > sum) ? (num - sum) / cnt : 0;
        end
        r.filtered        = res[FILT_W-1:0];
        r.neighbour_count = cnt[NCNT_W-1:0];
      end
      owed_means.push_back(r);
    endfunction

    function void check_result(input mean_result_t got);
      mean_result_t want;
      compared++;
      if (owed_means.size() == 0) begin
        errors++;
        $error("result word with no query outstanding: filtered %0d, neighbour_count %0d",
               got.filtered, got.neighbour_count);
        return;
      end
      want = owed_means.pop_front();
      if (got.filtered !== want.filtered) begin
        errors++;
        $error("filtered: expected %0d, actual %0d", want.filtered, got.filtered);
      end
      if (got.neighbour_count !== want.neighbour_count) begin
        errors++;
        $error("neighbour_count: expected %0d, actual %0d",
               want.neighbour_count, got.neighbour_count);
      end
    endfunction

    function int outstanding();
      return owed_means.size();
    endfunction
  endclass

  axial_mean_tracker tracker;

  // Generator-side state: what the bench has written so far, and the register
  // values it last programmed. Queries are only issued once every voxel they
  // read has been loaded.
  bit          written [VOXELS];
  cfg_t        gen_cfg;
  bit          steady     = 1'b0;  // sender offers words back to back
  bit          squeeze    = 1'b0;  // asks the receiver for its long hold-off
  int unsigned burst_left = 0;
  int unsigned nwords     = 0;
  int unsigned nqueries   = 0;
  int unsigned nphases    = 0;

  // ---------------------------------------------------------------------------
  // Monitor: every handshake is sampled at the rising edge, before the bench's
  // own nonblocking updates of that edge take effect.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        tracker.check_result('{filtered: rsp_ch.filtered,
                               neighbour_count: rsp_ch.neighbour_count});
      end
      if (req_ch.valid && req_ch.ready) begin
        tracker.take_word('{opcode: req_ch.opcode, x: req_ch.pos_x, y: req_ch.pos_y,
                            z: req_ch.pos_z, sample: req_ch.sample});
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        tracker.write_reg(cfg_ch.index, cfg_ch.data);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: cycles through four stall patterns, from always ready to ready
  // one cycle in three. Once asked, it holds ready low for a long stretch so
  // that the finished word sits in the output register, the next query waits
  // behind it and the input channel backs up.
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int unsigned cyc;
    bit          held;
    cyc  = 0;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (squeeze && !held) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      case ((cyc / 700) % 4)
        0:       rsp_ch.ready <= 1'b1;
        1:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
        2:       rsp_ch.ready <= (cyc % 3 == 0);
        default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks.
  // ---------------------------------------------------------------------------

  function automatic int pick_sample();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Offers one word and returns at the edge that accepts it. Valid is left
  // high so that a following word goes out without a bubble; a gap between
  // bursts lowers it first.
  task automatic send_word(input voxel_word_t w);
    int unsigned gap;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= w.opcode;
    req_ch.pos_x  <= w.x;
    req_ch.pos_y  <= w.y;
    req_ch.pos_z  <= w.z;
    req_ch.sample <= w.sample;
    do @(posedge clk); while (!req_ch.ready);
    nwords++;
    if (w.opcode == OP_QUERY) nqueries++;
  endtask

  task automatic load_voxel(input int x, input int y, input int z, input int value);
    voxel_word_t w;
    w.opcode = OP_LOAD;
    w.x      = x[COORD_W-1:0];
    w.y      = y[COORD_W-1:0];
    w.z      = z[COORD_W-1:0];
    w.sample = value[SAMPLE_W-1:0];
    written[voxel_addr(x, y, z)] = 1'b1;
    send_word(w);
  endtask

  // A well-formed sequence: loads for every voxel the query will read that
  // has not been written yet, then the query itself. A query outside the
  // volume reads nothing and goes out on its own.
  task automatic fill_and_query(input int x, input int y, input int z);
    int          taps[$];
    int          a;
    voxel_word_t w;
    if (gather_taps(gen_cfg, x, y, z, taps)) begin
      taps.push_back(voxel_addr(x, y, z));
      foreach (taps[i]) begin
        a = taps[i];
        if (!written[a]) begin
          load_voxel(a % MAX_X, (a / MAX_X) % MAX_Y, a / (MAX_X * MAX_Y), pick_sample());
        end
      end
    end
    w.opcode = OP_QUERY;
    w.x      = x[COORD_W-1:0];
    w.y      = y[COORD_W-1:0];
    w.z      = z[COORD_W-1:0];
    w.sample = $urandom_range(0, 255);  // ignored by a query, toggled anyway
    send_word(w);
  endtask

  // Drops valid, waits until the monitor has seen the last accepted word, then
  // for every owed result and then for the longest query, so that a register
  // write can never land on a busy block.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Valid stays high across back-to-back writes; the caller lowers it once.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_STEP:   gen_cfg.step   = value[STEP_W-1:0];
      CFG_REACH:  gen_cfg.reach  = value[REACH_W-1:0];
      CFG_SIZE_X: gen_cfg.size_x = value[SIZE_W-1:0];
      CFG_SIZE_Y: gen_cfg.size_y = value[SIZE_W-1:0];
      CFG_SIZE_Z: gen_cfg.size_z = value[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int st, input int rc, input int sx, input int sy,
                           input int sz);
    settle();
    write_reg(CFG_STEP, st);
    write_reg(CFG_REACH, rc);
    write_reg(CFG_SIZE_X, sx);
    write_reg(CFG_SIZE_Y, sy);
    write_reg(CFG_SIZE_Z, sz);
    cfg_ch.valid <= 1'b0;
    steady = ($urandom_range(0, 3) == 0);
    nphases++;
  endtask

  // Mostly queries inside the volume, with some anywhere in coordinate space
  // (often outside the volume) and some stray loads that overwrite voxels.
  task automatic random_items(input int budget);
    int stop_at, sx, sy, sz;
    stop_at = nwords + budget;
    sx = clip(gen_cfg.size_x, MAX_X);
    sy = clip(gen_cfg.size_y, MAX_Y);
    sz = clip(gen_cfg.size_z, MAX_Z);
    while (nwords < stop_at) begin
      case ($urandom_range(0, 9))
        0: load_voxel($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                      pick_sample());
        1: fill_and_query($urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 63));
        default: begin
          if (sx == 0 || sy == 0 || sz == 0) begin
            fill_and_query($urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 63));
          end else begin
            fill_and_query($urandom_range(0, sx - 1), $urandom_range(0, sy - 1),
                           $urandom_range(0, sz - 1));
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    tracker = new();
    gen_cfg = tracker.regs;

    req_ch.valid  <= 1'b0;
    req_ch.opcode <= OP_LOAD;
    req_ch.pos_x  <= '0;
    req_ch.pos_y  <= '0;
    req_ch.pos_z  <= '0;
    req_ch.sample <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= CFG_STEP;
    cfg_ch.data   <= '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset settings (step 5, reach 3, full volume):
    // corner voxels at full scale and at zero, so the clamp at zero is reached,
    // then a corner re-query after an overwrite.
    load_voxel(0, 0, 0, 255);
    fill_and_query(0, 0, 0);
    load_voxel(63, 63, 63, 0);
    fill_and_query(63, 63, 63);
    load_voxel(0, 0, 0, 0);
    fill_and_query(0, 0, 0);

    // Directed register settings. The first runs with the sender flat out and
    // triggers the receiver's long hold-off.
    configure(1, 8, 8, 8, 8);
    steady  = 1'b1;
    squeeze = 1'b1;
    random_items(110);
    // Step of zero: every ring sits on the centre voxel.
    configure(0, 2, 4, 4, 4);
    random_items(80);
    // Largest step, reach above its limit and sizes above the store.
    configure(63, 15, 127, 127, 127);
    fill_and_query(0, 0, 0);
    fill_and_query(63, 63, 63);
    random_items(80);
    // Reach of zero: the centre value comes back unchanged.
    configure(2, 0, 6, 5, 7);
    random_items(60);
    // Zero width: every query lies outside the volume.
    configure(3, 4, 0, 10, 10);
    random_items(60);
    // Single-voxel volume: no neighbour is ever in range.
    configure(1, 1, 1, 1, 1);
    random_items(40);
    // Full reach deep inside the volume, for all 48 neighbours at once.
    configure(3, 8, 64, 64, 64);
    fill_and_query(30, 31, 32);
    random_items(120);

    // Random settings, mostly small volumes, until the word budget is spent.
    while (nwords < ITEM_TARGET) begin
      configure(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 6),
                $urandom_range(0, 15),
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 10),
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 10),
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 10));
      random_items(90);
    end

    settle();

    $display("Covered %0d input words (%0d queries, %0d loads) over %0d register settings.",
             nwords, nqueries, nwords - nqueries, nphases + 1);
    $display("Compared %0d result words, %0d mismatches.", tracker.compared, tracker.errors);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb failed");
    $finish;
  end

endmodule
